// ===== rtl/core/rrts_pkg.sv =====
package rrts_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_TASKS_DEFAULT = 64;
   localparam int TIME_BITS_DEFAULT = 16;

   // Fixed field widths of the ports
   localparam int TAG_W     = 8;
   localparam int BURST_W   = 16;
   localparam int QUANTUM_W = 16;
   localparam int STATUS_W  = 2;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

   // Request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   // Response status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_LOADED   = 2'd0;
   localparam status_type ST_RAN      = 2'd1;
   localparam status_type ST_REJECTED = 2'd2;
   localparam status_type ST_IDLE_Q   = 2'd3;

endpackage

// ===== rtl/core/round_robin_task_scheduler_unit.sv =====
// Channel   Ports                                   Direction  Handshake
// req       action, task_tag, burst_time            in         req_valid / req_ready
// rsp       status, slice_tag, time_left,           out        rsp_valid / rsp_ready
//           time_used, finished, queue_empty
// csr       quantum                                 in         csr_wr_en (no wait)
//
// A load word, and a step word on an empty queue, are answered from the response
// register loaded at the accept edge. A step word on a busy queue first reads the
// head from the registered task RAM, then in S_SLICE computes the slice, writes an
// unfinished task back at tail and loads the response. Synchronous reset clears
// pointers, count, quantum (to 4) and the FSM; the RAM is not cleared, only occupied
// entries are read. A new word is taken only while the response register is free or
// being drained in that same cycle; rsp_ready low stalls req_ready.
module round_robin_task_scheduler_unit import rrts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [TAG_W-1:0]     req_task_tag,
   input  logic [BURST_W-1:0]   req_burst_time,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [TAG_W-1:0]     rsp_slice_tag,
   output logic [BURST_W-1:0]   rsp_time_left,
   output logic [BURST_W-1:0]   rsp_time_used,
   output logic                 rsp_finished,
   output logic                 rsp_queue_empty,
   // configuration
   input  logic                 csr_wr_en,
   input  logic [QUANTUM_W-1:0] csr_wr_data
);

   localparam int PW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNTW   = $clog2(MAX_TASKS + 1);
   localparam int DATA_W = TAG_W + TIME_BITS;
   // compare width: quantum is compared in full against the stored time
   localparam int CW     = (TIME_BITS > QUANTUM_W) ? TIME_BITS : QUANTUM_W;

   // FSM codes
   localparam logic S_IDLE  = 1'b0;
   localparam logic S_SLICE = 1'b1;

   logic                 state_ff, state_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [BURST_W-1:0]   left_ff, left_in;
   logic [BURST_W-1:0]   used_ff, used_in;
   logic                 fin_ff, fin_in;
   logic                 empty_ff, empty_in;

   // RAM ports
   logic                 wr_en;
   logic [PW-1:0]        wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic                 rd_en;
   logic [DATA_W-1:0]    rd_data;

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic [TIME_BITS-1:0] burst;
   logic [TIME_BITS-1:0] head_time;
   logic [TAG_W-1:0]     head_tag;
   logic [CW-1:0]        time_ext;
   logic [CW-1:0]        quant_ext;
   logic [CW-1:0]        diff;
   logic                 done;

   function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(MAX_TASKS - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNTW'(MAX_TASKS));
   assign empty     = (count_ff == '0);
   assign burst     = TIME_BITS'(req_burst_time);

   // slice arithmetic on the word read from the head
   assign head_time = rd_data[TIME_BITS-1:0];
   assign head_tag  = rd_data[TIME_BITS +: TAG_W];
   assign time_ext  = CW'(head_time);
   assign quant_ext = CW'(quantum_ff);
   assign diff      = time_ext - quant_ext;
   assign done      = (time_ext <= quant_ext);

   // Only one access per entry is in flight: a step reads at accept and writes
   // back in S_SLICE, during which no new word is taken, so no forwarding.
   assign rd_en = accept && (req_action == ACT_STEP) && !empty;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_ff;
      wr_data = {req_task_tag, burst};
      if (state_ff == S_SLICE) begin
         wr_en   = !done;
         wr_data = {head_tag, TIME_BITS'(diff)};
      end else if (accept && (req_action == ACT_LOAD)) begin
         wr_en = !full;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = wr_en ? wrap_next(tail_ff) : tail_ff;
      count_in     = count_ff;
      quantum_in   = csr_wr_en ? csr_wr_data : quantum_ff;

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) ? 1'b1 : 1'b0;
      status_in    = status_ff;
      tag_in       = tag_ff;
      left_in      = left_ff;
      used_in      = used_ff;
      fin_in       = fin_ff;
      empty_in     = empty_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_LOAD) begin
                  // load: append or drop, answer at once
                  rsp_valid_in = 1'b1;
                  tag_in       = req_task_tag;
                  left_in      = BURST_W'(burst);
                  used_in      = '0;
                  fin_in       = 1'b0;
                  empty_in     = 1'b0;
                  if (full) begin
                     status_in = ST_REJECTED;
                  end else begin
                     status_in = ST_LOADED;
                     count_in  = count_ff + CNTW'(1);
                  end
               end else if (empty) begin
                  // step on an empty queue: idle status
                  rsp_valid_in = 1'b1;
                  status_in    = ST_IDLE_Q;
                  tag_in       = '0;
                  left_in      = '0;
                  used_in      = '0;
                  fin_in       = 1'b0;
                  empty_in     = 1'b1;
               end else begin
                  // step: head read issued, advance head
                  head_in  = wrap_next(head_ff);
                  state_in = S_SLICE;
               end
            end
         end
         S_SLICE: begin
            // response slot is always free here
            rsp_valid_in = 1'b1;
            status_in    = ST_RAN;
            tag_in       = head_tag;
            fin_in       = done;
            if (done) begin
               left_in  = '0;
               used_in  = BURST_W'(time_ext);
               count_in = count_ff - CNTW'(1);
               empty_in = (count_ff == CNTW'(1));
            end else begin
               left_in  = BURST_W'(diff);
               used_in  = BURST_W'(quant_ext);
               empty_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      tag_ff    <= tag_in;
      left_ff   <= left_in;
      used_ff   <= used_in;
      fin_ff    <= fin_in;
      empty_ff  <= empty_in;
   end

   rrts_task_ram #(
      .DEPTH  (MAX_TASKS),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slice_tag   = tag_ff;
   assign rsp_time_left   = left_ff;
   assign rsp_time_used   = used_ff;
   assign rsp_finished    = fin_ff;
   assign rsp_queue_empty = empty_ff;

endmodule

// ===== rtl/core/rrts_task_ram.sv =====
module rrts_task_ram import rrts_pkg::*; #(
   parameter int DEPTH  = MAX_TASKS_DEFAULT,
   parameter int DATA_W = TAG_W + TIME_BITS_DEFAULT,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
